// File: rtl/core/fpas_pkg.sv
// Package for the single-precision adder/subtractor.
// Holds the operation codes, field constants and the stage payload types.
package fpas_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_RSUB = 2'd2,
    OP_RSV  = 2'd3
  } op_e;

  localparam logic [31:0] SGN_MASK  = 32'h8000_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] DEF_NAN   = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_ALL   = 8'hFF;

  // Payload leaving the front end: aligned significands, or a finished special result.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        big_s;
    logic        small_s;
    logic [9:0]  exp;
    logic [26:0] hi;
    logic [26:0] lo;
  } align_t;

  // Payload leaving the adder: raw magnitude before normalisation.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        sign;
    logic [9:0]  exp;
    logic [27:0] acc;
  } sum_t;

  // Payload leaving normalisation: hidden bit at 26, GRS in [2:0].
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        sign;
    logic [9:0]  exp;
    logic [26:0] w;
  } norm_t;

endpackage

// File: rtl/core/fpas_lzc.sv
// Leading-zero counter over the 28-bit sum, as a small priority tree.
// Depends on nothing but its ports.
module fpas_lzc (
  input  logic [27:0] val_i,
  output logic [4:0]  cnt_o
);
  logic [31:0] ext;
  logic [15:0] v16;
  logic [7:0]  v8;
  logic [3:0]  v4;
  logic [1:0]  v2;

  // Halve the search window at each level.
  always_comb begin
    ext       = {val_i, 4'hF};
    cnt_o     = '0;
    cnt_o[4]  = (ext[31:16] == '0);
    v16       = cnt_o[4] ? ext[15:0] : ext[31:16];
    cnt_o[3]  = (v16[15:8] == '0);
    v8        = cnt_o[3] ? v16[7:0] : v16[15:8];
    cnt_o[2]  = (v8[7:4] == '0);
    v4        = cnt_o[2] ? v8[3:0] : v8[7:4];
    cnt_o[1]  = (v4[3:2] == '0);
    v2        = cnt_o[1] ? v4[1:0] : v4[3:2];
    cnt_o[0]  = ~v2[1];
  end
endmodule

// File: rtl/core/fp32_add_subtract.sv
// Top level of the single-precision adder/subtractor, a five-stage pipeline.
// Uses fpas_pkg and the leading-zero counter fpas_lzc.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i, in_stall_o, opcode_i,         | in
//          | operand_a_i, operand_b_i                  |
//  result  | out_valid_o, out_stall_i, sum_bits_o      | out
//
// One request enters per cycle while the pipeline is not stalled; its result
// is valid on the output register of the fifth stage.
// Stages: decode/specials, align, add, normalise, round and pack.
// Reset clears only the valid bits of the stages.
// A stall from the result side holds the output and each full stage with no bubble ahead; a bubble in the
// pipeline is filled while the output waits, so no request is lost.
module fp32_add_subtract
  import fpas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sum_bits_o
);

  // Valid bits and advance enables, from the output back.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = ~v5_q | ~out_stall_i;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign in_stall_o = ~en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- Stage 1: operand selection, specials, exponent order.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        big_s;
    logic        small_s;
    logic [9:0]  exp;
    logic [23:0] big_m;
    logic [23:0] small_m;
    logic [4:0]  gap;
    logic        far;
  } dec_t;

  dec_t s1_d, s1_q;
  logic [31:0] p, q;
  logic p_nan, q_nan, p_inf, q_inf, p_zero, q_zero, p_sub, q_sub;
  logic [9:0] pe, qe;
  logic [23:0] pm, qm;
  logic [9:0] diff;
  logic swap;

  always_comb begin
    unique case (op_e'(opcode_i))
      OP_SUB:  begin p = operand_a_i; q = operand_b_i ^ SGN_MASK; end
      OP_RSUB: begin p = operand_b_i; q = operand_a_i ^ SGN_MASK; end
      default: begin p = operand_a_i; q = operand_b_i; end
    endcase
    p_nan  = (p[30:23] == EXP_ALL) && (p[22:0] != '0);
    q_nan  = (q[30:23] == EXP_ALL) && (q[22:0] != '0);
    p_inf  = (p[30:23] == EXP_ALL) && (p[22:0] == '0);
    q_inf  = (q[30:23] == EXP_ALL) && (q[22:0] == '0);
    p_zero = (p[30:0] == '0);
    q_zero = (q[30:0] == '0);
    p_sub  = (p[30:23] == '0);
    q_sub  = (q[30:23] == '0);
    // Subnormals use exponent 1 with no hidden bit; same value as normalising.
    pe = p_sub ? 10'd1 : {2'b00, p[30:23]};
    qe = q_sub ? 10'd1 : {2'b00, q[30:23]};
    pm = {~p_sub, p[22:0]};
    qm = {~q_sub, q[22:0]};

    s1_d.special  = 1'b1;
    s1_d.spec_res = '0;
    if (p_nan)                s1_d.spec_res = p | QUIET_BIT;
    else if (q_nan)           s1_d.spec_res = q | QUIET_BIT;
    else if (p_inf && q_inf)  s1_d.spec_res = (p[31] ^ q[31]) ? DEF_NAN : p;
    else if (p_inf)           s1_d.spec_res = p;
    else if (q_inf)           s1_d.spec_res = q;
    else if (p_zero && q_zero) s1_d.spec_res = {p[31] & q[31], 31'd0};
    else if (p_zero)          s1_d.spec_res = q;
    else if (q_zero)          s1_d.spec_res = p;
    else                      s1_d.special = 1'b0;

    swap = (pe < qe);
    diff = swap ? (qe - pe) : (pe - qe);
    s1_d.big_s   = swap ? q[31] : p[31];
    s1_d.small_s = swap ? p[31] : q[31];
    s1_d.exp     = swap ? qe : pe;
    s1_d.big_m   = swap ? qm : pm;
    s1_d.small_m = swap ? pm : qm;
    s1_d.far     = (diff > 10'd27);
    s1_d.gap     = diff[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
  end

  // ---------------- Stage 2: alignment shift with sticky.
  align_t s2_d, s2_q;
  logic [26:0] lo_w;
  logic [26:0] lo_sh;
  logic [26:0] lost_mask;

  always_comb begin
    lo_w      = {s1_q.small_m, 3'b000};
    lo_sh     = lo_w >> s1_q.gap;
    lost_mask = ~(27'h7FF_FFFF << s1_q.gap);
    s2_d.special  = s1_q.special;
    s2_d.spec_res = s1_q.spec_res;
    s2_d.big_s    = s1_q.big_s;
    s2_d.small_s  = s1_q.small_s;
    s2_d.exp      = s1_q.exp;
    s2_d.hi       = {s1_q.big_m, 3'b000};
    if (s1_q.far) s2_d.lo = 27'd1;
    else s2_d.lo = lo_sh | {26'd0, (lo_w & lost_mask) != '0};
  end

  always_ff @(posedge clk_i) begin
    if (en2) s2_q <= s2_d;
  end

  // ---------------- Stage 3: add or subtract magnitudes.
  sum_t s3_d, s3_q;

  always_comb begin
    s3_d.special  = s2_q.special;
    s3_d.spec_res = s2_q.spec_res;
    s3_d.exp      = s2_q.exp;
    s3_d.sign     = s2_q.big_s;
    if (s2_q.big_s == s2_q.small_s) begin
      s3_d.acc = {1'b0, s2_q.hi} + {1'b0, s2_q.lo};
    end else if (s2_q.hi < s2_q.lo) begin
      s3_d.acc  = {1'b0, s2_q.lo - s2_q.hi};
      s3_d.sign = s2_q.small_s;
    end else begin
      s3_d.acc = {1'b0, s2_q.hi - s2_q.lo};
    end
    // Exact cancellation gives +0.
    if (s3_d.acc == '0) s3_d.sign = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en3) s3_q <= s3_d;
  end

  // ---------------- Stage 4: normalise; left shift limited to the subnormal floor.
  norm_t s4_d, s4_q;
  logic [4:0] lz;
  logic [9:0] room;
  logic [4:0] lsh;

  fpas_lzc u_lzc (
    .val_i (s3_q.acc),
    .cnt_o (lz)
  );

  always_comb begin
    s4_d.special  = s3_q.special;
    s4_d.spec_res = s3_q.spec_res;
    s4_d.sign     = s3_q.sign;
    room = s3_q.exp - 10'd1;
    s4_d.exp = s3_q.exp;
    s4_d.w   = s3_q.acc[26:0];
    lsh      = '0;
    if (s3_q.acc[27]) begin
      s4_d.w   = s3_q.acc[27:1] | {26'd0, s3_q.acc[0]};
      s4_d.exp = s3_q.exp + 10'd1;
    end else if (s3_q.acc != '0) begin
      // Shift to bit 26 but never below exponent 1.
      lsh = ({5'd0, lz} - 10'd1 > room) ? room[4:0] : lz - 5'd1;
      s4_d.w   = s3_q.acc[26:0] << lsh;
      s4_d.exp = s3_q.exp - {5'd0, lsh};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) s4_q <= s4_d;
  end

  // ---------------- Stage 5: round to nearest even and pack.
  logic [31:0] res_d, res_q;
  logic [24:0] m_rnd;
  logic [9:0]  e_rnd;
  logic        up;

  always_comb begin
    up    = s4_q.w[2] & (s4_q.w[1] | s4_q.w[0] | s4_q.w[3]);
    m_rnd = {1'b0, s4_q.w[26:3]} + {24'd0, up};
    e_rnd = s4_q.exp;
    if (m_rnd[24]) begin
      m_rnd = m_rnd >> 1;
      e_rnd = e_rnd + 10'd1;
    end
    if (s4_q.special) res_d = s4_q.spec_res;
    else if (s4_q.w == '0) res_d = {s4_q.sign, 31'd0};
    else if (e_rnd >= 10'd255) res_d = {s4_q.sign, EXP_ALL, 23'd0};
    else if (!m_rnd[23]) res_d = {s4_q.sign, 8'd0, m_rnd[22:0]};
    else res_d = {s4_q.sign, e_rnd[7:0], m_rnd[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en5) res_q <= res_d;
  end

  assign out_valid_o = v5_q;
  assign sum_bits_o  = res_q;

`ifndef ASSERT_OFF
  // A held result stays put while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sum_bits_o))
    else $error("result changed under stall");
  // The input side only stalls when the whole pipe is full and blocked.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i)
    else $error("spurious input stall");
  // A normal result leaves normalisation with its hidden bit set or at minimum exponent.
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !s4_q.special && s4_q.w != '0 |-> s4_q.w[26] || s4_q.exp == 10'd1)
    else $error("normalisation left the significand unaligned");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the single-precision adder/subtractor fp32_add_subtract.
// Depends on fpas_pkg for the operation codes; results are predicted in the bench itself.
module testbench;
  import fpas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_ADD;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] sum_bits_o;

  logic [31:0] sums_due[$];
  int          fail_count = 0;
  bit          quiet_phase = 1'b0;
  bit          long_hold = 1'b0;

  fp32_add_subtract uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .sum_bits_o(sum_bits_o)
  );

  always #5 clk_i = ~clk_i;

  // Generous overall limit on the run.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit is_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] v);
    return v[30:0] == 31'h7F80_0000;
  endfunction

  // Round a magnitude with hidden bit at 26 and guard, round and sticky below.
  function automatic logic [31:0] pack_rounded(logic sgn, int ex, logic [31:0] w);
    logic [31:0] m;
    logic [2:0]  tail;
    int          sh;
    if (w == 0) return {sgn, 31'd0};
    if (ex < -126) begin
      sh = -126 - ex;
      if (sh >= 32) w = 1;
      else w = (w >> sh) | ((w & ((32'd1 << sh) - 1)) != 0);
      ex = -126;
    end
    tail = w[2:0];
    m = w >> 3;
    if (tail > 4 || (tail == 4 && m[0])) begin
      m++;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        ex++;
      end
    end
    if (ex >= 128) return {sgn, 31'h7F80_0000};
    if (m == 0) return {sgn, 31'd0};
    if (!m[23]) return {sgn, m[30:0]};
    return {sgn, 8'(ex + 127), m[22:0]};
  endfunction

  // Rounded sum of two operands, first operand p, second q.
  function automatic logic [31:0] fp_sum(logic [31:0] p, logic [31:0] q);
    logic        ps, qs, rs, ts;
    logic [31:0] pm, qm, hi, lo, acc, tm;
    int          pe, qe, te, gap;
    if (is_nan(p)) return p | QUIET_BIT;
    if (is_nan(q)) return q | QUIET_BIT;
    if (is_inf(p) && is_inf(q)) return (p[31] != q[31]) ? DEF_NAN : p;
    if (is_inf(p)) return p;
    if (is_inf(q)) return q;
    ps = p[31];
    qs = q[31];
    pe = (p[30:23] == 0) ? -126 : int'(p[30:23]) - 127;
    qe = (q[30:23] == 0) ? -126 : int'(q[30:23]) - 127;
    pm = {8'd0, p[30:23] != 0, p[22:0]};
    qm = {8'd0, q[30:23] != 0, q[22:0]};
    if (pm == 0 && qm == 0) return {ps & qs, 31'd0};
    if (pm == 0) return q;
    if (qm == 0) return p;
    // Normalise subnormal significands.
    while (!pm[23]) begin pm = pm << 1; pe--; end
    while (!qm[23]) begin qm = qm << 1; qe--; end
    if (pe < qe) begin
      ts = ps; ps = qs; qs = ts;
      tm = pm; pm = qm; qm = tm;
      te = pe; pe = qe; qe = te;
    end
    hi = pm << 3;
    lo = qm << 3;
    gap = pe - qe;
    if (gap >= 31) lo = 1;
    else if (gap > 0) lo = (lo >> gap) | ((lo & ((32'd1 << gap) - 1)) != 0);
    rs = ps;
    if (ps == qs) begin
      acc = hi + lo;
      if (acc[27]) begin
        acc = (acc >> 1) | acc[0];
        pe++;
      end
    end else begin
      if (hi < lo) begin
        acc = lo - hi;
        rs = qs;
      end else acc = hi - lo;
      if (acc == 0) return 32'd0;
      while (!acc[26]) begin acc = acc << 1; pe--; end
    end
    return pack_rounded(rs, pe, acc);
  endfunction

  function automatic logic [31:0] predict_sum(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    case (op)
      OP_SUB:  return fp_sum(a, b ^ SGN_MASK);
      OP_RSUB: return fp_sum(b, a ^ SGN_MASK);
      default: return fp_sum(a, b);
    endcase
  endfunction

  // Random operand that favours special patterns and near exponents.
  function automatic logic [31:0] pick_operand(logic [31:0] other);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:0] = 31'h7F80_0000;
      3: v[30:0] = 31'd0;
      4: v[30:23] = other[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
      5: v = other ^ 32'($urandom_range(0, 7));
      6: v[30:23] = 8'($urandom_range(250, 254));
      default: ;
    endcase
    return v;
  endfunction

  // Offer one request, sometimes after an idle gap, and hold it until it is accepted.
  task automatic send_request(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                              logic [31:0] fixed_sum, bit has_fixed);
    logic [31:0] due;
    due = predict_sum(op, a, b);
    if (has_fixed && due != fixed_sum) begin
      $error("table row: sum_bits expected %h, predictor gives %h", fixed_sum, due);
      fail_count++;
    end
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    sums_due.push_back(due);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap_len;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        gap_len = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (gap_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        $error("sum_bits: unexpected result %h", sum_bits_o);
        fail_count++;
      end else begin
        want = sums_due.pop_front();
        if (sum_bits_o !== want) begin
          $error("sum_bits: expected %h, actual %h", want, sum_bits_o);
          fail_count++;
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    bit          fixed;
  } row_t;

  // Directed table: extremes, every operation and the special cases.
  row_t rows[] = '{
    '{OP_ADD,  32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1},
    '{OP_SUB,  32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 1},
    '{OP_RSUB, 32'h4000_0000, 32'h3F80_0000, 32'hBF80_0000, 1},
    '{OP_RSV,  32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1},
    '{OP_ADD,  32'h7F80_0001, 32'hFFC0_0002, 32'h7FC0_0001, 1},
    '{OP_SUB,  32'h3F80_0000, 32'h7F80_0005, 32'hFFC0_0005, 1},
    '{OP_RSUB, 32'h7F80_0003, 32'h7FA0_0000, 32'h7FE0_0000, 1},
    '{OP_ADD,  32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 1},
    '{OP_SUB,  32'h7F80_0000, 32'h7F80_0000, 32'h7FC0_0000, 1},
    '{OP_ADD,  32'hFF80_0000, 32'h3F80_0000, 32'hFF80_0000, 1},
    '{OP_ADD,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1},
    '{OP_ADD,  32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1},
    '{OP_SUB,  32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1},
    '{OP_ADD,  32'h0000_0000, 32'hC0A0_0000, 32'hC0A0_0000, 1},
    '{OP_ADD,  32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 1},
    '{OP_ADD,  32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000, 1},
    '{OP_ADD,  32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 1},
    '{OP_SUB,  32'h0080_0000, 32'h007F_FFFF, 32'h0000_0001, 1},
    '{OP_ADD,  32'h4B80_0000, 32'h3F80_0000, 32'h0, 0},
    '{OP_ADD,  32'h3F80_0001, 32'h3380_0000, 32'h0, 0},
    '{OP_SUB,  32'h3F80_0000, 32'h3380_0001, 32'h0, 0},
    '{OP_ADD,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 0},
    '{OP_RSUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000, 1},
    '{OP_ADD,  32'h7F7F_FFFF, 32'h0000_0001, 32'h0, 0}
  };

  // Main sequence: reset, directed table, random requests, drain.
  initial begin
    logic [31:0] a;
    int          guard;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      send_request(rows[i].op, rows[i].a, rows[i].b, rows[i].sum, rows[i].fixed);
    for (int n = 0; n < 1950; n++) begin
      if (n == 400) long_hold = 1'b1;
      if (n == 900) begin
        // Pause the sender until every result has come back.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sums_due.size() != 0) @(posedge clk_i);
      end
      if (n == 1700) quiet_phase = 1'b1;
      a = pick_operand($urandom);
      send_request(2'($urandom_range(0, 3)), a, pick_operand(a), '0, 0);
    end
    in_valid_i <= 1'b0;
    guard = 0;
    while (sums_due.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (sums_due.size() != 0) begin
      $error("sum_bits: %0d expected results never arrived", sums_due.size());
      fail_count++;
    end
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
